// File: src/weighted_running_mean_variance_macros.svh
// assertion macros for the weighted running mean/variance block
// no dependencies; included by the files that carry assertions
`ifndef WEIGHTED_RUNNING_MEAN_VARIANCE_MACROS_SVH
`define WEIGHTED_RUNNING_MEAN_VARIANCE_MACROS_SVH
`ifndef SYNTH
`define WRMV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WRMV_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WRMV_ASSERT(label, clk, rst_n, prop, msg)
`define WRMV_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: src/wrmv_pkg.sv
// shared constants and types of the weighted running mean/variance block
// no dependencies
package wrmv_pkg;

	localparam int CountWidth = 32;

	localparam logic [62:0] V63Max = {63{1'b1}};
	localparam logic [40:0] StepLim = {1'b1, 40'b0};

	// request to the shared multiply/divide unit
	typedef struct packed {
		logic        start;
		logic        div;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} mdu_req_t;

	// status and result of the shared unit
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} mdu_rsp_t;

endpackage

// File: src/wrmv_mdu.sv
// shared multiply/divide unit: trunc(a*b/d) saturating at 2^64-1, or low 64 bits of a*b
// depends on wrmv_pkg
module wrmv_mdu (
	input  logic               clk,
	input  logic               arst_n,
	input  wrmv_pkg::mdu_req_t req,
	output wrmv_pkg::mdu_rsp_t rsp
);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

	state_t         state_q;
	logic [1:0]     idx_q;
	logic [5:0]     bit_q;
	logic [63:0]    a_q, b_q, d_q;
	logic           div_q;
	logic [127:0]   acc_q;

	logic [31:0]    a_half, b_half;
	logic [63:0]    pp;
	logic [127:0]   pp_sh, acc_next;
	logic [64:0]    trial;
	logic           ge;
	logic [64:0]    diff;

	// one 32x32 partial product per cycle
	always_comb begin
		a_half = idx_q[1] ? a_q[63:32] : a_q[31:0];
		b_half = idx_q[0] ? b_q[63:32] : b_q[31:0];
		pp = 64'(a_half) * 64'(b_half);
		case ({1'b0, idx_q[1]} + {1'b0, idx_q[0]})
			2'd0: pp_sh = {64'b0, pp};
			2'd1: pp_sh = {32'b0, pp, 32'b0};
			2'd2: pp_sh = {pp, 64'b0};
			default: pp_sh = 128'b0;
		endcase
		acc_next = acc_q + pp_sh;
	end

	// restoring division step, one quotient bit per cycle
	always_comb begin
		trial = {acc_q[127:64], acc_q[63]};
		ge = trial >= {1'b0, d_q};
		diff = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			bit_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						a_q <= req.a;
						b_q <= req.b;
						d_q <= req.d;
						div_q <= req.div;
						acc_q <= '0;
						idx_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						if (!div_q) begin
							acc_q <= acc_next;
							state_q <= S_DONE;
						end else if (d_q == 64'b0 || acc_next[127:64] >= d_q) begin
							acc_q <= {acc_next[127:64], {64{1'b1}}};
							state_q <= S_DONE;
						end else begin
							acc_q <= acc_next;
							bit_q <= '0;
							state_q <= S_DIV;
						end
					end else begin
						acc_q <= acc_next;
					end
				end
				S_DIV: begin
					acc_q <= {(ge ? diff[63:0] : trial[63:0]), acc_q[62:0], ge};
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd63) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.busy = (state_q != S_IDLE);
	assign rsp.done = (state_q == S_DONE);
	assign rsp.result = acc_q[63:0];

endmodule

// File: src/weighted_running_mean_variance.sv
// Weighted running mean and variance accumulator. One request carries a command in s_tuser
// (0 adds the weighted sample, 1 clears all statistics) and a Q16.16 value and weight; each
// request gives one result with the statistics after it. The block takes one request at a
// time. A clear or a zero-weight sample goes straight to its result; a first sample, a
// restart or a zero-total sample takes one multiply, and a weighted update takes two
// multiplies and four multiply-divide passes through the one shared unit (4 partial
// products, then a 64-step restoring division). The block is ready again in the cycle
// after the result is taken.
// depends on wrmv_pkg, wrmv_mdu and weighted_running_mean_variance_macros.svh
`include "weighted_running_mean_variance_macros.svh"
module weighted_running_mean_variance (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // sample_value, sample_weight
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	// entry_count, weight_total, weight_square_total, running_mean, running_variance,
	// value_low, value_high, zero pad
	output logic [303:0] m_tdata,
	output logic [1:0]   m_tuser   // sample_ignored, zero_total_flag
);

	typedef enum logic [2:0] {S_IDLE, S_EVAL, S_CALC, S_FIN, S_OUT} state_t;
	typedef enum logic [2:0] {OP_WSQ, OP_STEP, OP_T1, OP_DSQ, OP_X, OP_T2} op_t;

	state_t state_q;
	op_t    op_q;
	logic   start_q;

	logic                               cmd_q;
	logic signed [31:0]                 value_q, weight_q;
	logic [wrmv_pkg::CountWidth-1:0]    count_q;
	logic signed [47:0]                 wsum_q;
	logic [62:0]                        wsqs_q;
	logic signed [31:0]                 mean_q;
	logic [62:0]                        var_q;
	logic signed [31:0]                 min_q, max_q;
	logic                               ign_q, zf_q;
	logic [63:0]                        wsq_q, q_q, t1_q, dsq_q, x_q, t2_q;

	wrmv_pkg::mdu_req_t req;
	wrmv_pkg::mdu_rsp_t rsp;

	wrmv_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// operand magnitudes and signs, stable while the request is worked on
	logic signed [32:0] delta;
	logic [32:0]        ad;
	logic [31:0]        bw;
	logic [47:0]        aw;
	logic signed [48:0] tot;
	logic [48:0]        tw;
	logic               simple;

	always_comb begin
		delta = $signed({value_q[31], value_q}) - $signed({mean_q[31], mean_q});
		ad = delta[32] ? 33'(-delta) : 33'(delta);
		bw = weight_q[31] ? 32'(-weight_q) : 32'(weight_q);
		aw = wsum_q[47] ? 48'(-wsum_q) : 48'(wsum_q);
		tot = $signed({wsum_q[47], wsum_q}) + $signed({{17{weight_q[31]}}, weight_q});
		tw = tot[48] ? 49'(-tot) : 49'(tot);
		simple = (count_q == '0) || (wsum_q == '0) || (tot == '0);
	end

	// operand select for the shared unit
	always_comb begin
		req.start = start_q;
		req.div = 1'b1;
		req.d = 64'(tw);
		case (op_q)
			OP_WSQ: begin
				req.a = 64'(bw);
				req.b = 64'(bw);
				req.div = 1'b0;
			end
			OP_STEP: begin
				req.a = 64'(ad);
				req.b = 64'(bw);
			end
			OP_T1: begin
				req.a = 64'(aw);
				req.b = 64'(var_q);
			end
			OP_DSQ: begin
				req.a = 64'(ad);
				req.b = 64'(ad);
				req.div = 1'b0;
			end
			OP_X: begin
				req.a = 64'(aw);
				req.b = dsq_q;
			end
			OP_T2: begin
				req.a = x_q;
				req.b = 64'(bw);
			end
			default: begin
				req.a = '0;
				req.b = '0;
			end
		endcase
	end

	// weighted mean step
	logic [40:0]        qc;
	logic signed [42:0] step, msum;
	logic signed [31:0] mean_new;

	always_comb begin
		qc = (q_q > 64'(wrmv_pkg::StepLim)) ? wrmv_pkg::StepLim : q_q[40:0];
		step = (weight_q[31] ^ delta[32] ^ tot[48]) ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
		msum = $signed({{11{mean_q[31]}}, mean_q}) + step;
		if (msum[42:31] != {12{msum[42]}}) begin
			mean_new = msum[42] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			mean_new = msum[31:0];
		end
	end

	// variance combine of the two signed terms
	logic [62:0] t1c, t2c, var_new;
	logic [63:0] mg;
	logic        n1, n2, vneg;

	always_comb begin
		t1c = t1_q[63] ? wrmv_pkg::V63Max : t1_q[62:0];
		t2c = t2_q[63] ? wrmv_pkg::V63Max : t2_q[62:0];
		n1 = wsum_q[47] ^ tot[48];
		n2 = wsum_q[47] ^ weight_q[31];
		if (n1 == n2) begin
			mg = {1'b0, t1c} + {1'b0, t2c};
			vneg = n1;
		end else if (t1c >= t2c) begin
			mg = {1'b0, t1c} - {1'b0, t2c};
			vneg = n1;
		end else begin
			mg = {1'b0, t2c} - {1'b0, t1c};
			vneg = n2;
		end
		var_new = vneg ? '0 : (mg[63] ? wrmv_pkg::V63Max : mg[62:0]);
	end

	// sums that update with every accepted sample of non-zero weight
	logic [63:0] wsq_sum;
	logic [47:0] wsum_new;

	always_comb begin
		wsq_sum = {1'b0, wsqs_q} + wsq_q;
		if (tot[48] != tot[47]) begin
			wsum_new = tot[48] ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
		end else begin
			wsum_new = tot[47:0];
		end
	end

	// sequencer and statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_WSQ;
			start_q <= 1'b0;
			count_q <= '0;
			wsum_q <= '0;
			wsqs_q <= '0;
			mean_q <= '0;
			var_q <= '0;
			min_q <= '0;
			max_q <= '0;
			ign_q <= 1'b0;
			zf_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tuser;
						value_q <= s_tdata[31:0];
						weight_q <= s_tdata[63:32];
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					zf_q <= 1'b0;
					if (cmd_q) begin
						ign_q <= 1'b0;
						count_q <= '0;
						wsum_q <= '0;
						wsqs_q <= '0;
						mean_q <= '0;
						var_q <= '0;
						min_q <= '0;
						max_q <= '0;
						state_q <= S_OUT;
					end else if (weight_q == '0) begin
						ign_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						ign_q <= 1'b0;
						op_q <= OP_WSQ;
						start_q <= 1'b1;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (rsp.done) begin
						case (op_q)
							OP_WSQ: begin
								wsq_q <= rsp.result;
								if (simple) begin
									state_q <= S_FIN;
								end else begin
									op_q <= OP_STEP;
									start_q <= 1'b1;
								end
							end
							OP_STEP: begin
								q_q <= rsp.result;
								op_q <= OP_T1;
								start_q <= 1'b1;
							end
							OP_T1: begin
								t1_q <= rsp.result;
								op_q <= OP_DSQ;
								start_q <= 1'b1;
							end
							OP_DSQ: begin
								dsq_q <= rsp.result;
								op_q <= OP_X;
								start_q <= 1'b1;
							end
							OP_X: begin
								x_q <= rsp.result;
								op_q <= OP_T2;
								start_q <= 1'b1;
							end
							OP_T2: begin
								t2_q <= rsp.result;
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end else begin
						start_q <= 1'b0;
					end
				end
				S_FIN: begin
					if (count_q == '0) begin
						mean_q <= value_q;
						var_q <= '0;
						min_q <= value_q;
						max_q <= value_q;
					end else begin
						if (wsum_q == '0) begin
							mean_q <= value_q;
							var_q <= '0;
						end else if (tot == '0) begin
							zf_q <= 1'b1;
						end else begin
							mean_q <= mean_new;
							var_q <= var_new;
						end
						if (value_q < min_q) begin
							min_q <= value_q;
						end
						if (value_q > max_q) begin
							max_q <= value_q;
						end
					end
					if (count_q != '1) begin
						count_q <= count_q + {{(wrmv_pkg::CountWidth-1){1'b0}}, 1'b1};
					end
					wsum_q <= wsum_new;
					wsqs_q <= wsq_sum[63] ? wrmv_pkg::V63Max : wsq_sum[62:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result fields straight from the statistics registers
	logic [47:0] count_ext;
	logic [31:0] count_out;

	always_comb begin
		count_ext = 48'(count_q);
		count_out = (count_ext > 48'h0000FFFFFFFF) ? 32'hFFFFFFFF : count_ext[31:0];
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {2'b00, max_q, min_q, var_q, mean_q, wsqs_q, wsum_q, count_out};
	assign m_tuser = {zf_q, ign_q};

	// checks
	`WRMV_NEVER(a_ready_while_result, clk, arst_n, s_tready && m_tvalid, "new request taken while result pending")
	`WRMV_NEVER(a_ready_while_busy, clk, arst_n, s_tready && rsp.busy, "request taken while unit busy")
	`WRMV_NEVER(a_both_flags, clk, arst_n, ign_q && zf_q, "ignored and zero-total flags together")
	`WRMV_ASSERT(a_start_idle, clk, arst_n, start_q |-> !rsp.busy, "unit started while busy")

endmodule
